[design/tcce_pkg.sv]
// ============================================================================
// tcce_pkg: shared types and constants of the text console cursor engine
// Field widths, operation and register codes, command/result/config beats
// and the backspace flag rule.
// ============================================================================
package tcce_pkg;

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHR_W  = 8;
    localparam int STOP_W = 8;

    // Default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed values
    localparam logic [ROW_W-1:0] MIN_START_ROW  = 5'd3;
    localparam logic [ROW_W-1:0] CUR_ROW_RST    = 5'd3;
    localparam logic [CHR_W-1:0] ATTR_HIGHLIGHT = 8'h30;
    localparam logic [CHR_W-1:0] ATTR_NORMAL    = 8'h0F;
    localparam logic [CHR_W-1:0] BLANK_CHAR     = 8'h20;

    // Operation codes
    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_NL     = 3'd1,
        OP_BS     = 3'd2,
        OP_SET    = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_READ   = 3'd5,
        OP_HL     = 3'd6,
        OP_UNHL   = 3'd7
    } t_op;

    // Register indexes
    typedef enum logic [1:0] {
        REG_START_COL = 2'd0,
        REG_START_ROW = 2'd1,
        REG_BS_STOP   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    // Command beat
    typedef struct packed {
        logic [2:0]       operation;
        logic [CHR_W-1:0] character;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [CHR_W-1:0] read_char;
        logic [CHR_W-1:0] read_attr;
        logic             read_ok;
        logic [ROW_W-1:0] cursor_row_out;
        logic [COL_W-1:0] cursor_col_out;
        logic             backspace_allowed;
    } t_result;

    // Configuration registers
    typedef struct packed {
        logic [COL_W-1:0]         start_column;
        logic [ROW_W-1:0]         start_row;
        logic signed [STOP_W-1:0] backspace_stop;
    } t_cfg;

    // Cursor unit answer
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             scroll;
        logic             ok;
    } t_cur_next;

    // Backspace allowed: negative stop, or stop not above the column
    function automatic logic bs_allowed(input logic signed [STOP_W-1:0] stop,
                                        input logic [COL_W-1:0] col);
        logic signed [STOP_W-1:0] col_s;
        col_s = $signed(STOP_W'(col));
        return stop[STOP_W-1] || (col_s >= stop);
    endfunction

endpackage

[design/tcce_ram.sv]
// ============================================================================
// tcce_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcce_cursor.sv]
// ============================================================================
// tcce_cursor: next-cursor logic
// Works out the cursor after one command, whether a scroll is needed and
// whether the addressed position is valid.
// ============================================================================
module tcce_cursor
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  t_cmd             i_cmd,
    input  logic [ROW_W-1:0] i_cur_row,
    input  logic [COL_W-1:0] i_cur_col,
    input  t_cfg             i_cfg,
    output t_cur_next        o_next
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);

    logic ok;

    assign ok = ({1'b0, i_cmd.row} < ROW_LIM) && ({1'b0, i_cmd.column} < COL_LIM);

    always_comb begin
        o_next.row    = i_cur_row;
        o_next.col    = i_cur_col;
        o_next.scroll = 1'b0;
        o_next.ok     = ok;
        case (i_cmd.operation)
            OP_PUT: begin
                if (i_cur_col >= LAST_COL) begin
                    if (i_cur_row >= LAST_ROW) begin
                        o_next.scroll = 1'b1;
                        o_next.row    = LAST_ROW;
                    end else begin
                        o_next.row = i_cur_row + 1'b1;
                    end
                    o_next.col = i_cfg.start_column;
                end else begin
                    o_next.col = i_cur_col + 1'b1;
                end
            end
            OP_NL: begin
                if (i_cur_row >= LAST_ROW) begin
                    o_next.scroll = 1'b1;
                    o_next.row    = LAST_ROW;
                end else begin
                    o_next.row = i_cur_row + 1'b1;
                end
                o_next.col = i_cfg.start_column;
            end
            OP_BS: begin
                // at the start column step back to the previous row end,
                // except on the region top row or the first row
                if (i_cur_col == i_cfg.start_column) begin
                    if (i_cur_row != i_cfg.start_row && i_cur_row != '0) begin
                        o_next.row = i_cur_row - 1'b1;
                        o_next.col = LAST_COL;
                    end
                end else if (i_cur_col != '0) begin
                    o_next.col = i_cur_col - 1'b1;
                end
            end
            OP_SET: begin
                if (ok) begin
                    o_next.row = i_cmd.row;
                    o_next.col = i_cmd.column;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[design/text_console_cursor_engine_core.sv]
// ============================================================================
// text_console_cursor_engine_core: text-mode console with cursor
// Character and attribute stores, cursor, scroll, clear, cell read and
// highlight, with an APB-style register port.
// ============================================================================
// A command is taken when start is high and busy is low; its result shows
// on o_result for exactly one cycle, marked by o_result_valid, and the
// receiver cannot stall it. For put char without wrap-scroll, new line
// without scroll, backspace, set cursor, (un)highlight and a read of an
// invalid position the result follows in the next cycle and busy stays low.
// A read of a valid cell goes through the read state (registered store
// read) before its result is registered. A scroll walks the store through
// one shared address counter, one cell a cycle: a copy of any rows below
// start_row one row up, a drain step and blanking of the bottom row. Clear
// walks all ROWS*COLUMNS cells. After reset a clearing pass over all cells
// zeroes both stores with busy high; register writes are taken throughout.
module text_console_cursor_engine_core
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    // result channel
    output logic        o_result_valid,
    output t_result     o_result,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int                CELLS       = ROWS * COLUMNS;
    localparam int                AW          = $clog2(CELLS);
    localparam logic [AW-1:0]     COLS_A      = AW'(COLUMNS);
    localparam logic [AW-1:0]     LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0]     BOTTOM_ADDR = AW'((ROWS - 1) * COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_COPY  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_BLANK = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
        return AW'(r) * COLS_A + AW'(c);
    endfunction

    t_state           r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_wr_pend, n_wr_pend;
    logic [AW-1:0]    r_wr_addr, n_wr_addr;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic             r_out_valid, n_out_valid;
    t_result          r_result, n_result;
    t_cfg             r_cfg;

    logic             accept;
    t_cur_next        cur_next;
    logic [AW-1:0]    cmd_addr;
    logic [AW-1:0]    cur_addr;
    logic             chr_we, atr_we;
    logic [AW-1:0]    chr_waddr, atr_waddr, rd_addr;
    logic [CHR_W-1:0] chr_wdata, atr_wdata, chr_rdata, atr_rdata;
    logic             cfg_wr;
    logic [COL_W-1:0] wr_col;
    logic [ROW_W-1:0] wr_row;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign cmd_addr = cell_addr(i_cmd.row, i_cmd.column);
    assign cur_addr = cell_addr(r_cur_row, r_cur_col);

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // saturated write values
    always_comb begin
        wr_col = pwdata[COL_W-1:0];
        if (wr_col > LAST_COL) begin
            wr_col = LAST_COL;
        end
        wr_row = pwdata[ROW_W-1:0];
        if (wr_row > LAST_ROW) begin
            wr_row = LAST_ROW;
        end
        if (wr_row < MIN_START_ROW) begin
            wr_row = MIN_START_ROW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_column   <= '0;
            r_cfg.start_row      <= MIN_START_ROW;
            r_cfg.backspace_stop <= '1;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_START_COL: r_cfg.start_column   <= wr_col;
                REG_START_ROW: r_cfg.start_row      <= wr_row;
                REG_BS_STOP:   r_cfg.backspace_stop <= pwdata[STOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_START_COL: prdata = 32'(r_cfg.start_column);
            REG_START_ROW: prdata = 32'(r_cfg.start_row);
            REG_BS_STOP:   prdata = 32'($unsigned(r_cfg.backspace_stop));
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Cursor unit
    // ------------------------------------------------------------------
    tcce_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_cmd     (i_cmd),
        .i_cur_row (r_cur_row),
        .i_cur_col (r_cur_col),
        .i_cfg     (r_cfg),
        .o_next    (cur_next)
    );

    // ------------------------------------------------------------------
    // Store ports
    // ------------------------------------------------------------------
    always_comb begin
        chr_we    = 1'b0;
        chr_waddr = r_addr;
        chr_wdata = BLANK_CHAR;
        atr_we    = 1'b0;
        atr_waddr = r_addr;
        atr_wdata = ATTR_NORMAL;
        rd_addr   = (r_state == S_COPY) ? r_addr : cmd_addr;
        if (r_wr_pend) begin
            // copy beat read last cycle lands one row up
            chr_we    = 1'b1;
            chr_waddr = r_wr_addr;
            chr_wdata = chr_rdata;
        end else begin
            case (r_state)
                S_INIT: begin
                    chr_we    = 1'b1;
                    chr_wdata = '0;
                    atr_we    = 1'b1;
                    atr_wdata = '0;
                end
                S_CLEAR: begin
                    chr_we = 1'b1;
                    atr_we = 1'b1;
                end
                S_BLANK: begin
                    chr_we = 1'b1;
                end
                S_IDLE: begin
                    if (accept && i_cmd.operation == OP_PUT) begin
                        chr_we    = 1'b1;
                        chr_waddr = cur_addr;
                        chr_wdata = i_cmd.character;
                    end
                    if (accept && cur_next.ok &&
                        (i_cmd.operation == OP_HL || i_cmd.operation == OP_UNHL)) begin
                        atr_we    = 1'b1;
                        atr_waddr = cmd_addr;
                        atr_wdata = (i_cmd.operation == OP_HL) ? ATTR_HIGHLIGHT
                                                               : ATTR_NORMAL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    tcce_ram #(
        .WIDTH (CHR_W),
        .DEPTH (CELLS)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (chr_waddr),
        .i_wdata (chr_wdata),
        .i_raddr (rd_addr),
        .o_rdata (chr_rdata)
    );

    tcce_ram #(
        .WIDTH (CHR_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (atr_we),
        .i_waddr (atr_waddr),
        .i_wdata (atr_wdata),
        .i_raddr (rd_addr),
        .o_rdata (atr_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_out_valid = 1'b0;
        n_result    = r_result;
        case (r_state)
            S_INIT: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cur_row = cur_next.row;
                    n_cur_col = cur_next.col;
                    if (cur_next.scroll) begin
                        if (r_cfg.start_row >= LAST_ROW) begin
                            n_state = S_BLANK;
                            n_addr  = BOTTOM_ADDR;
                        end else begin
                            n_state = S_COPY;
                            n_addr  = cell_addr(r_cfg.start_row + 1'b1, '0);
                        end
                    end else if (i_cmd.operation == OP_CLEAR) begin
                        n_state = S_CLEAR;
                        n_addr  = '0;
                    end else if (i_cmd.operation == OP_READ && cur_next.ok) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid                = 1'b1;
                        n_result.read_char         = '0;
                        n_result.read_attr         = '0;
                        n_result.read_ok           = 1'b0;
                        n_result.cursor_row_out    = cur_next.row;
                        n_result.cursor_col_out    = cur_next.col;
                        n_result.backspace_allowed = bs_allowed(r_cfg.backspace_stop,
                                                                cur_next.col);
                    end
                end
            end
            S_READ: begin
                n_state                    = S_IDLE;
                n_out_valid                = 1'b1;
                n_result.read_char         = chr_rdata;
                n_result.read_attr         = atr_rdata;
                n_result.read_ok           = 1'b1;
                n_result.cursor_row_out    = r_cur_row;
                n_result.cursor_col_out    = r_cur_col;
                n_result.backspace_allowed = bs_allowed(r_cfg.backspace_stop, r_cur_col);
            end
            S_COPY: begin
                n_addr    = r_addr + 1'b1;
                n_wr_pend = 1'b1;
                n_wr_addr = r_addr - COLS_A;
                if (r_addr == LAST_CELL) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_BLANK;
                n_addr  = BOTTOM_ADDR;
            end
            S_BLANK, S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_CELL) begin
                    n_state                    = S_IDLE;
                    n_out_valid                = 1'b1;
                    n_result.read_char         = '0;
                    n_result.read_attr         = '0;
                    n_result.read_ok           = 1'b0;
                    n_result.cursor_row_out    = r_cur_row;
                    n_result.cursor_col_out    = r_cur_col;
                    n_result.backspace_allowed = bs_allowed(r_cfg.backspace_stop,
                                                            r_cur_col);
                end
            end
            default: begin
                n_state = S_INIT;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_wr_pend   <= 1'b0;
            r_cur_row   <= CUR_ROW_RST;
            r_cur_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_wr_pend   <= n_wr_pend;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_result  <= n_result;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

`ifndef ASSERT_OFF
    // cursor never leaves the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur_row) < ROWS) && (int'(r_cur_col) < COLUMNS))
        else $error("cursor outside the screen");

    // a pending copy write only follows a copy read beat
    a_pend_after_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(r_state == S_COPY))
        else $error("copy write without copy read");

    // no result during the power-on clearing pass
    a_no_result_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_result_valid)
        else $error("result during clearing pass");

    // a flagged read comes only out of the read state
    a_read_ok_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.read_ok) |-> $past(r_state == S_READ))
        else $error("read_ok outside a read");

    // a scroll ends with the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLANK) |-> (r_cur_row == LAST_ROW))
        else $error("scroll with cursor off the bottom row");
`endif

endmodule
